[hdl/lbs_pkg.sv]
`timescale 1ns / 1ps
package lbs_pkg;

    localparam int MaxJoints  = 64;
    localparam int FracBits   = 16;
    localparam int MatElems   = 12;
    localparam int StoreDepth = MaxJoints * MatElems;
    localparam int AddrW      = $clog2(StoreDepth);
    localparam int WeightFrac = 16;

    localparam logic [1:0] REQ_LOAD_WORLD = 2'd0;
    localparam logic [1:0] REQ_LOAD_INV   = 2'd1;
    localparam logic [1:0] REQ_INFLUENCE  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         joint_index;
        logic [3:0]         matrix_slot;
        logic signed [31:0] matrix_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [16:0]        weight;
        logic               last_influence;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_nrm_x;
        logic signed [31:0] out_nrm_y;
        logic signed [31:0] out_nrm_z;
    } out_item_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

[hdl/linear_blend_skinning.sv]
`timescale 1ns / 1ps
// Linear blend skinning engine. Load transfers write one element of the
// world or inverse bind matrix stores (two RAMs with one write port and one
// registered read port, addressed by joint*12+slot). An influence
// transfer is worked through by one shared multiplier: each of the
// four matrix-vector steps reads one matrix element per cycle from RAM,
// 12 reads whose data pass the RAM read register and the multiplier
// product register; each of the two weight steps follows a pair of matrix
// steps, and a final state finishes the vertex. The input stalls while an
// influence is worked through, so none is accepted before it is done. The
// result on a last influence sits in an output register; while it waits
// and the receiver stalls, the input stalls as well.
module linear_blend_skinning (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lbs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lbs_pkg::out_item_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAT,
        ST_WGT,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   busy;

    // Sequencing registers.
    logic [1:0]  pass_reg;
    logic [3:0]  cnt_reg;
    logic [1:0]  vec_reg;
    logic [5:0]  joint_reg;
    logic [16:0] wt_reg;
    logic        last_reg;
    logic        valid_j_reg;
    logic signed [31:0] vin_reg [3];
    logic signed [31:0] pin_reg [3];
    logic signed [31:0] nin_reg [3];
    logic signed [65:0] sum_reg [3];
    logic signed [31:0] pacc_reg [3];
    logic signed [31:0] nacc_reg [3];
    logic               outv_reg;
    lbs_pkg::out_item_t out_reg;

    // Pipeline tags for the multiplier (issue -> rdata -> product).
    logic       t1_v_reg, t2_v_reg;
    logic [3:0] t1_s_reg, t2_s_reg;

    logic                       acc_in;
    logic                       ld_w, ld_i;
    logic [lbs_pkg::AddrW-1:0]  waddr, raddr;
    logic [31:0]                w_rdata, i_rdata;
    logic signed [31:0]         mat_el;
    logic signed [31:0]         mat_el_d2_reg;
    logic signed [32:0]         ma, mb;
    logic [4:0]                 msh;
    logic signed [65:0]         mp;
    logic                       in_range;

    // Column of an affine element index (translation column maps to 0,
    // its product is not used).
    function automatic logic [1:0] slot_col(input logic [3:0] s);
        logic [1:0] c;
        if (s inside {[4'd3:4'd5]})
            c = 2'd1;
        else if (s inside {[4'd6:4'd8]})
            c = 2'd2;
        else
            c = 2'd0;
        return c;
    endfunction

    // Row of an affine element index.
    function automatic logic [1:0] slot_row(input logic [3:0] s);
        logic [1:0] r;
        if (s inside {4'd1, 4'd4, 4'd7, 4'd10})
            r = 2'd1;
        else if (s inside {4'd2, 4'd5, 4'd8, 4'd11})
            r = 2'd2;
        else
            r = 2'd0;
        return r;
    endfunction

    assign busy     = (state_reg != ST_IDLE);
    assign in_stall = busy || (outv_reg && out_stall);
    assign acc_in   = in_valid && !in_stall;
    assign in_range = ({2'b00, in_data.joint_index} < 8'(lbs_pkg::MaxJoints))
                      && (in_data.matrix_slot < 4'(lbs_pkg::MatElems));
    assign ld_w = acc_in && in_data.req_type == lbs_pkg::REQ_LOAD_WORLD && in_range;
    assign ld_i = acc_in && in_data.req_type == lbs_pkg::REQ_LOAD_INV && in_range;
    assign waddr = lbs_pkg::AddrW'(in_data.joint_index * 10'd12 + in_data.matrix_slot);
    assign raddr = lbs_pkg::AddrW'(joint_reg * 10'd12 + cnt_reg);

    lbs_ram #(.Width(32), .Depth(lbs_pkg::StoreDepth)) u_world (
        .clk(clk), .we(ld_w), .waddr(waddr), .wdata(in_data.matrix_value),
        .raddr(raddr), .rdata(w_rdata)
    );
    lbs_ram #(.Width(32), .Depth(lbs_pkg::StoreDepth)) u_inv (
        .clk(clk), .we(ld_i), .waddr(waddr), .wdata(in_data.matrix_value),
        .raddr(raddr), .rdata(i_rdata)
    );

    // Passes 0 and 2 use the inverse bind store, 1 and 3 the world store.
    assign mat_el = pass_reg[0] ? w_rdata : i_rdata;

    // Multiplier operand select: matrix element times vector, or weight.
    always_comb
    begin
        if (state_reg == ST_WGT)
        begin
            ma  = {16'd0, wt_reg};
            mb  = 33'(vin_reg[vec_reg]);
            msh = 5'(lbs_pkg::WeightFrac);
        end
        else
        begin
            ma  = 33'(mat_el);
            mb  = 33'(vin_reg[slot_col(t1_s_reg)]);
            msh = 5'(lbs_pkg::FracBits);
        end
    end

    lbs_mac u_mac (.clk(clk), .a(ma), .b(mb), .shift(msh), .prod_shifted(mp));

    logic [1:0]  row2;
    logic        is_trans2;
    logic        w_one;
    logic [1:0]  wv_reg;
    logic        wv_v_reg;

    assign row2      = slot_row(t2_s_reg);
    assign is_trans2 = t2_s_reg >= 4'd9;
    assign w_one     = (pass_reg < 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            outv_reg  <= 1'b0;
            t1_v_reg  <= 1'b0;
            t2_v_reg  <= 1'b0;
            wv_v_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pacc_reg[i] <= '0;
                nacc_reg[i] <= '0;
            end
        end
        else
        begin
            if (outv_reg && !out_stall)
            begin
                outv_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in && in_data.req_type == lbs_pkg::REQ_INFLUENCE)
                    begin
                        joint_reg   <= in_data.joint_index;
                        wt_reg      <= in_data.weight;
                        last_reg    <= in_data.last_influence;
                        valid_j_reg <= ({2'b00, in_data.joint_index}
                                        < 8'(lbs_pkg::MaxJoints));
                        pin_reg[0] <= in_data.pos_x;
                        pin_reg[1] <= in_data.pos_y;
                        pin_reg[2] <= in_data.pos_z;
                        nin_reg[0] <= in_data.nrm_x;
                        nin_reg[1] <= in_data.nrm_y;
                        nin_reg[2] <= in_data.nrm_z;
                        vin_reg[0] <= in_data.pos_x;
                        vin_reg[1] <= in_data.pos_y;
                        vin_reg[2] <= in_data.pos_z;
                        pass_reg <= 2'd0;
                        cnt_reg  <= 4'd0;
                        for (int i = 0; i < 3; i++)
                            sum_reg[i] <= '0;
                        state_reg <= ST_MAT;
                    end
                end
                ST_MAT:
                begin
                    // Issue one read per cycle; tags follow the RAM and multiplier.
                    t1_v_reg <= (cnt_reg < 4'd12);
                    t1_s_reg <= cnt_reg;
                    t2_v_reg <= t1_v_reg;
                    t2_s_reg <= t1_s_reg;
                    if (!t1_v_reg && t2_v_reg)
                    begin
                        // Pass complete: saturated rows become next vector.
                        for (int i = 0; i < 3; i++)
                        begin
                            vin_reg[i] <= lbs_pkg::sat32(
                                (t2_s_reg >= 4'd9 && row2 == 2'(i))
                                ? (w_one ? sum_reg[i] + 66'(mat_el_d2_reg) : sum_reg[i])
                                : sum_reg[i]);
                            sum_reg[i] <= '0;
                        end
                        cnt_reg <= 4'd0;
                        if (pass_reg[0])
                        begin
                            vec_reg   <= 2'd0;
                            wv_v_reg  <= 1'b0;
                            state_reg <= ST_WGT;
                        end
                        else
                            pass_reg <= pass_reg + 2'd1;
                    end
                    else
                    begin
                        if (cnt_reg < 4'd12)
                            cnt_reg <= cnt_reg + 4'd1;
                        if (t2_v_reg)
                        begin
                            if (is_trans2)
                            begin
                                if (w_one)
                                    sum_reg[row2] <= sum_reg[row2] + 66'(mat_el_d2_reg);
                            end
                            else
                                sum_reg[row2] <= sum_reg[row2] + mp;
                        end
                    end
                end
                ST_WGT:
                begin
                    // Weight products, one per cycle, added in the next cycle.
                    wv_reg <= vec_reg;
                    if (vec_reg < 2'd3)
                        vec_reg <= vec_reg + 2'd1;
                    if (wv_v_reg && valid_j_reg)
                    begin
                        if (pass_reg == 2'd1)
                            pacc_reg[wv_reg] <= lbs_pkg::sat32(
                                66'(pacc_reg[wv_reg]) + mp);
                        else
                            nacc_reg[wv_reg] <= lbs_pkg::sat32(
                                66'(nacc_reg[wv_reg]) + mp);
                    end
                    if (wv_v_reg && wv_reg == 2'd2)
                    begin
                        wv_v_reg <= 1'b0;
                        if (pass_reg == 2'd1)
                        begin
                            pass_reg  <= 2'd2;
                            cnt_reg   <= 4'd0;
                            vin_reg   <= nin_reg;
                            state_reg <= ST_MAT;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                    else
                        wv_v_reg <= (vec_reg < 2'd3);
                end
                ST_DONE:
                begin
                    if (last_reg)
                    begin
                        out_reg.out_pos_x <= pacc_reg[0];
                        out_reg.out_pos_y <= pacc_reg[1];
                        out_reg.out_pos_z <= pacc_reg[2];
                        out_reg.out_nrm_x <= nacc_reg[0];
                        out_reg.out_nrm_y <= nacc_reg[1];
                        out_reg.out_nrm_z <= nacc_reg[2];
                        outv_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            pacc_reg[i] <= '0;
                            nacc_reg[i] <= '0;
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Matrix element delayed to line up with the product (translation add).
    always_ff @(posedge clk)
    begin
        mat_el_d2_reg <= mat_el;
    end

    assign out_valid = outv_reg;
    assign out_data  = out_reg;

endmodule

[hdl/lbs_ram.sv]
`timescale 1ns / 1ps
module lbs_ram #(
    parameter int Width = 32,
    parameter int Depth = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/lbs_mac.sv]
`timescale 1ns / 1ps
module lbs_mac (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    input  logic [4:0]         shift,
    output logic signed [65:0] prod_shifted
);

    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;

    // One signed product per cycle, registered before the floor shift.
    assign prod_next = 66'(a) * 66'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod_shifted = prod_reg >>> shift;

endmodule
